// ===== design/bfha_pkg.sv =====
// Package with the shared constants, types and micro-operation codes of the heap allocator.
package bfha_pkg;

  localparam int unsigned HEAP_WORDS = 4096;
  localparam int unsigned WORD_BITS  = 16;
  localparam int unsigned IDX_W      = $clog2(HEAP_WORDS);
  localparam int unsigned HW_W       = 13;
  localparam int unsigned ADDR_W     = WORD_BITS + 2;
  localparam int unsigned SIZE_W     = 12;
  localparam int unsigned OFF_W      = 12;

  localparam logic [WORD_BITS-1:0] NIL_WORD  = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] USED_WORD = {{(WORD_BITS-1){1'b1}}, 1'b0};
  localparam logic [HW_W-1:0]      HW_MIN    = HW_W'(8);
  localparam logic [HW_W-1:0]      HW_MAX    = HW_W'(HEAP_WORDS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_BF_INIT,
    OP_RD_C,
    OP_BF_SZ,
    OP_BF_NEXT,
    OP_CV_TAIL,
    OP_CV_USED,
    OP_CV_HEAD,
    OP_RD_1,
    OP_RD_0,
    OP_MG_INIT,
    OP_MG_RDC,
    OP_MG_CSZ,
    OP_MG_PN,
    OP_MG_CN,
    OP_MG_WP,
    OP_MG_WPN,
    OP_FR_RD,
    OP_FR_EVAL,
    OP_FR_WN,
    OP_RES_OK,
    OP_RES_FAIL,
    OP_RES_FREE
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_BF_CHK,
    ST_BF_SZ,
    ST_BF_NX,
    ST_BF_END,
    ST_CV_TAIL,
    ST_CV_USED,
    ST_CV_HEAD,
    ST_MG_R1,
    ST_MG_INIT,
    ST_MG_CHK,
    ST_MG_CSZ,
    ST_MG_PN,
    ST_MG_CN,
    ST_MG_WP,
    ST_MG_WPN,
    ST_FR_RD,
    ST_FR_EVAL,
    ST_FR_WN,
    ST_DONE_OK,
    ST_DONE_FAIL,
    ST_DONE_FREE
  } state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic op_free;
    logic off_small;
    logic walk_ok;
    logic found;
    logic rd_nil;
    logic mg_ok;
    logic both_free;
    logic fr_cont;
  } dp_status_t;

endpackage

// ===== design/bfha_in_if.sv =====
// Request channel interface of the heap allocator.
interface bfha_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [bfha_pkg::SIZE_W-1:0] request_size;
  logic [bfha_pkg::OFF_W-1:0]  block_offset;

  modport source (output valid, output operation, output request_size, output block_offset,
                  input ready);
  modport sink (input valid, input operation, input request_size, input block_offset,
                output ready);
endinterface

// ===== design/bfha_out_if.sv =====
// Result channel interface of the heap allocator.
interface bfha_out_if;
  logic                      valid;
  logic                      ready;
  logic [bfha_pkg::OFF_W-1:0] data_offset;
  logic                      status;

  modport source (output valid, output data_offset, output status, input ready);
  modport sink (input valid, input data_offset, input status, output ready);
endinterface

// ===== design/bfha_dp.sv =====
// Datapath of the heap allocator: heap memory, header registers, cursors and result register.
module bfha_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bfha_pkg::dp_cmd_t            cmd_i,
  input  logic                         cfg_we_i,
  input  logic [bfha_pkg::HW_W-1:0]    cfg_wdata_i,
  input  logic                         operation_i,
  input  logic [bfha_pkg::SIZE_W-1:0]  request_size_i,
  input  logic [bfha_pkg::OFF_W-1:0]   block_offset_i,
  output bfha_pkg::dp_status_t         status_o,
  output logic [bfha_pkg::OFF_W-1:0]   data_offset_o,
  output logic                         fail_o
);
  import bfha_pkg::*;

  word_t           mem [HEAP_WORDS];
  word_t           mem_q;
  word_t           h0_q, h1_q;
  logic [HW_W-1:0] hw_q;
  addr_t           rd_addr_q;
  word_t           rdata;

  logic              op_q;
  logic [SIZE_W-1:0] s_q;
  logic [OFF_W-1:0]  off_q;
  addr_t             n_q, c_q, p_q, best_q, tail_q, nextc_q;
  word_t             sz_q, bestsz_q, csz_q, pn_q, cn_q, tmp_q;
  logic              found_q;
  logic [HW_W-1:0]   steps_q;
  logic [OFF_W-1:0]  res_off_q;
  logic              res_fail_q;

  logic  rd_en, wr_en;
  addr_t rd_addr, wr_addr;
  word_t wr_data;
  addr_t hw_ext, s_ext, tail_calc, sum_c;
  logic [HW_W-1:0] hw_new;

  assign hw_ext    = addr_t'(hw_q);
  assign s_ext     = addr_t'(s_q);
  assign tail_calc = best_q + addr_t'(bestsz_q) - s_ext;
  assign sum_c     = c_q + addr_t'(csz_q) + addr_t'(2);

  always_comb begin
    if (rd_addr_q >= hw_ext) begin
      rdata = '0;
    end else if (rd_addr_q == addr_t'(0)) begin
      rdata = h0_q;
    end else if (rd_addr_q == addr_t'(1)) begin
      rdata = h1_q;
    end else begin
      rdata = mem_q;
    end
  end

  always_comb begin
    if (cfg_wdata_i < HW_MIN) begin
      hw_new = HW_MIN;
    end else if (cfg_wdata_i > HW_MAX) begin
      hw_new = HW_MAX;
    end else begin
      hw_new = cfg_wdata_i;
    end
  end

  always_comb begin
    status_o.op_free   = op_q;
    status_o.off_small = off_q < OFF_W'(2);
    status_o.walk_ok   = (c_q != addr_t'(NIL_WORD)) && (c_q + addr_t'(1) < hw_ext) &&
                         (steps_q < hw_q);
    status_o.found     = found_q;
    status_o.rd_nil    = rdata == NIL_WORD;
    status_o.mg_ok     = (c_q <= hw_ext - addr_t'(1)) && (steps_q < hw_q);
    status_o.both_free = (pn_q != USED_WORD) && (rdata != USED_WORD);
    status_o.fr_cont   = (rdata != NIL_WORD) && (addr_t'(rdata) < n_q) && (steps_q < hw_q);
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (cmd_i.op)
      OP_RD_C:    begin rd_en = 1'b1; rd_addr = c_q; end
      OP_BF_SZ:   begin rd_en = 1'b1; rd_addr = c_q + addr_t'(1); end
      OP_RD_1:    begin rd_en = 1'b1; rd_addr = addr_t'(1); end
      OP_RD_0:    begin rd_en = 1'b1; rd_addr = addr_t'(0); end
      OP_MG_RDC:  begin rd_en = 1'b1; rd_addr = c_q; end
      OP_MG_CSZ:  begin rd_en = 1'b1; rd_addr = p_q + addr_t'(1); end
      OP_MG_PN:   begin rd_en = 1'b1; rd_addr = c_q + addr_t'(1); end
      OP_MG_CN:   begin rd_en = status_o.both_free; rd_addr = p_q; end
      OP_FR_RD:   begin rd_en = 1'b1; rd_addr = c_q + addr_t'(1); end
      OP_CV_TAIL: begin wr_en = 1'b1; wr_addr = tail_calc; wr_data = word_t'(s_q); end
      OP_CV_USED: begin wr_en = 1'b1; wr_addr = tail_q + addr_t'(1); wr_data = USED_WORD; end
      OP_CV_HEAD: begin
        wr_en   = 1'b1;
        wr_addr = best_q;
        wr_data = bestsz_q - word_t'(s_q) - word_t'(2);
      end
      OP_MG_WP: begin
        wr_en   = 1'b1;
        wr_addr = p_q;
        wr_data = rdata + csz_q + word_t'(2);
      end
      OP_MG_WPN:  begin wr_en = 1'b1; wr_addr = p_q + addr_t'(1); wr_data = cn_q; end
      OP_FR_EVAL: begin
        wr_en   = !status_o.fr_cont;
        wr_addr = c_q + addr_t'(1);
        wr_data = word_t'(n_q);
      end
      OP_FR_WN:   begin wr_en = 1'b1; wr_addr = n_q + addr_t'(1); wr_data = tmp_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && (wr_addr >= addr_t'(2)) && (wr_addr < hw_ext)) begin
      mem[wr_addr[IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= HW_MAX;
      h0_q <= word_t'(HW_MAX - HW_W'(2));
      h1_q <= NIL_WORD;
    end else if (cfg_we_i) begin
      hw_q <= hw_new;
      h0_q <= word_t'(hw_new - HW_W'(2));
      h1_q <= NIL_WORD;
    end else if (wr_en && (wr_addr < hw_ext)) begin
      if (wr_addr == addr_t'(0)) begin
        h0_q <= wr_data;
      end else if (wr_addr == addr_t'(1)) begin
        h1_q <= wr_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        op_q    <= operation_i;
        s_q     <= request_size_i;
        off_q   <= block_offset_i;
        n_q     <= addr_t'(block_offset_i) - addr_t'(2);
        c_q     <= '0;
        steps_q <= '0;
        found_q <= 1'b0;
      end
      OP_BF_INIT: begin
        c_q     <= '0;
        steps_q <= '0;
        found_q <= 1'b0;
      end
      OP_BF_SZ: sz_q <= rdata;
      OP_BF_NEXT: begin
        if ((addr_t'(sz_q) >= s_ext + addr_t'(2)) && (!found_q || (sz_q < bestsz_q))) begin
          best_q   <= c_q;
          bestsz_q <= sz_q;
          found_q  <= 1'b1;
        end
        c_q     <= addr_t'(rdata);
        steps_q <= steps_q + HW_W'(1);
      end
      OP_CV_TAIL: tail_q <= tail_calc;
      OP_MG_INIT: begin
        c_q     <= addr_t'(rdata) + addr_t'(2);
        p_q     <= '0;
        steps_q <= '0;
      end
      OP_MG_CSZ: csz_q <= rdata;
      OP_MG_PN:  pn_q <= rdata;
      OP_MG_CN: begin
        cn_q    <= rdata;
        nextc_q <= sum_c;
        if (!status_o.both_free) begin
          p_q     <= c_q;
          c_q     <= sum_c;
          steps_q <= steps_q + HW_W'(1);
        end
      end
      OP_MG_WPN: begin
        c_q     <= nextc_q;
        steps_q <= steps_q + HW_W'(1);
      end
      OP_FR_EVAL: begin
        if (status_o.fr_cont) begin
          c_q     <= addr_t'(rdata);
          steps_q <= steps_q + HW_W'(1);
        end else begin
          tmp_q <= rdata;
        end
      end
      OP_RES_OK: begin
        res_off_q  <= tail_q[OFF_W-1:0] + OFF_W'(2);
        res_fail_q <= 1'b0;
      end
      OP_RES_FAIL: begin
        res_off_q  <= '0;
        res_fail_q <= 1'b1;
      end
      OP_RES_FREE: begin
        res_off_q  <= '0;
        res_fail_q <= 1'b0;
      end
      default: ;
    endcase
  end

  assign data_offset_o = res_off_q;
  assign fail_o        = res_fail_q;

`ifndef SYNTHESIS
  a_no_rd_wr: assert property (@(posedge clk_i) disable iff (!rst_ni) !(rd_en && wr_en))
    else $error("heap memory read and written in the same cycle");
  a_cfg_format: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (h1_q == NIL_WORD) && (h0_q == word_t'(hw_q - HW_W'(2))))
    else $error("heap not formatted after configuration write");
  a_hw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hw_q >= HW_MIN) && (hw_q <= HW_MAX))
    else $error("heap size register out of range");
`endif
endmodule

// ===== design/bfha_ctrl.sv =====
// Controller state machine of the heap allocator: sequences list walks, carving, merging and results.
module bfha_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  bfha_pkg::dp_status_t status_i,
  output bfha_pkg::dp_cmd_t    cmd_o
);
  import bfha_pkg::*;

  state_e state_q, state_d;
  logic   retried_q, retried_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free, res_set;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      retried_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      retried_q   <= retried_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    retried_d  = retried_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    res_set    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op  = OP_LOAD;
          retried_d = 1'b0;
          state_d   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status_i.op_free) begin
          state_d = status_i.off_small ? ST_DONE_FREE : ST_FR_RD;
        end else begin
          state_d = ST_BF_CHK;
        end
      end
      ST_BF_CHK: begin
        if (status_i.walk_ok) begin
          cmd_o.op = OP_RD_C;
          state_d  = ST_BF_SZ;
        end else begin
          state_d = ST_BF_END;
        end
      end
      ST_BF_SZ: begin
        cmd_o.op = OP_BF_SZ;
        state_d  = ST_BF_NX;
      end
      ST_BF_NX: begin
        cmd_o.op = OP_BF_NEXT;
        state_d  = ST_BF_CHK;
      end
      ST_BF_END: begin
        if (status_i.found) begin
          state_d = ST_CV_TAIL;
        end else if (retried_q) begin
          state_d = ST_DONE_FAIL;
        end else begin
          cmd_o.op = OP_RD_1;
          state_d  = ST_MG_R1;
        end
      end
      ST_CV_TAIL: begin
        cmd_o.op = OP_CV_TAIL;
        state_d  = ST_CV_USED;
      end
      ST_CV_USED: begin
        cmd_o.op = OP_CV_USED;
        state_d  = ST_CV_HEAD;
      end
      ST_CV_HEAD: begin
        cmd_o.op = OP_CV_HEAD;
        state_d  = ST_DONE_OK;
      end
      ST_MG_R1: begin
        if (status_i.rd_nil) begin
          cmd_o.op  = OP_BF_INIT;
          retried_d = 1'b1;
          state_d   = ST_BF_CHK;
        end else begin
          cmd_o.op = OP_RD_0;
          state_d  = ST_MG_INIT;
        end
      end
      ST_MG_INIT: begin
        cmd_o.op = OP_MG_INIT;
        state_d  = ST_MG_CHK;
      end
      ST_MG_CHK: begin
        if (status_i.mg_ok) begin
          cmd_o.op = OP_MG_RDC;
          state_d  = ST_MG_CSZ;
        end else begin
          cmd_o.op  = OP_BF_INIT;
          retried_d = 1'b1;
          state_d   = ST_BF_CHK;
        end
      end
      ST_MG_CSZ: begin
        cmd_o.op = OP_MG_CSZ;
        state_d  = ST_MG_PN;
      end
      ST_MG_PN: begin
        cmd_o.op = OP_MG_PN;
        state_d  = ST_MG_CN;
      end
      ST_MG_CN: begin
        cmd_o.op = OP_MG_CN;
        state_d  = status_i.both_free ? ST_MG_WP : ST_MG_CHK;
      end
      ST_MG_WP: begin
        cmd_o.op = OP_MG_WP;
        state_d  = ST_MG_WPN;
      end
      ST_MG_WPN: begin
        cmd_o.op = OP_MG_WPN;
        state_d  = ST_MG_CHK;
      end
      ST_FR_RD: begin
        cmd_o.op = OP_FR_RD;
        state_d  = ST_FR_EVAL;
      end
      ST_FR_EVAL: begin
        cmd_o.op = OP_FR_EVAL;
        state_d  = status_i.fr_cont ? ST_FR_RD : ST_FR_WN;
      end
      ST_FR_WN: begin
        cmd_o.op = OP_FR_WN;
        state_d  = ST_DONE_FREE;
      end
      ST_DONE_OK: begin
        if (slot_free) begin
          cmd_o.op = OP_RES_OK;
          res_set  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_DONE_FAIL: begin
        if (slot_free) begin
          cmd_o.op = OP_RES_FAIL;
          res_set  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_DONE_FREE: begin
        if (slot_free) begin
          cmd_o.op = OP_RES_FREE;
          res_set  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = res_set || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_res_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_set |-> slot_free)
    else $error("result written while the previous one is still pending");
  a_retry_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE_FAIL) |-> retried_q)
    else $error("allocation failed without a merge and retry");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_LOAD) |=> (state_q == ST_DISPATCH))
    else $error("request loaded without dispatch");
`endif
endmodule

// ===== design/best_fit_heap_allocator_top.sv =====
// Top level of the best-fit heap allocator.
// Each transaction on the request channel allocates or frees one block of a word-addressed heap
// held in a single-port memory, and gives exactly one transaction on the result channel. Every
// heap access uses that memory port, so how long a request takes depends on the data: a free
// walks the free list up to the place of the block, and an allocation walks the whole free
// list and, when nothing fits, adds a merge sweep over the heap blocks (unless the free list is
// empty) and a second walk. A write to the heap size register formats the heap as one free
// block at once; it must only be made while no request is in progress.
module best_fit_heap_allocator_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bfha_pkg::HW_W-1:0] cfg_wdata_i,
  bfha_in_if.sink                   in_i,
  bfha_out_if.source                out_o
);
  import bfha_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  bfha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bfha_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (in_i.operation),
    .request_size_i (in_i.request_size),
    .block_offset_i (in_i.block_offset),
    .status_o       (status),
    .data_offset_o  (out_o.data_offset),
    .fail_o         (out_o.status)
  );
endmodule

// ===== bench/tb_best_fit_heap_allocator_top.sv =====
// Self-checking testbench for the best-fit heap allocator with a built-in heap predictor.
`timescale 1ns / 100ps

module tb_best_fit_heap_allocator_top;
  import bfha_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum logic {REQ_ALLOC = 1'b0, REQ_FREE = 1'b1} req_op_e;
  typedef enum logic {ST_DONE = 1'b0, ST_NO_SPACE = 1'b1} res_status_e;

  typedef struct packed {
    logic [OFF_W-1:0] data_offset;
    logic             status;
  } alloc_result_t;

  class heap_scoreboard;
    word_t           heap [HEAP_WORDS];
    longint unsigned words_in_use;
    alloc_result_t   awaited [$];
    int unsigned     mismatches;
    longint unsigned last_handle;

    function void format_heap(longint unsigned hw);
      words_in_use = hw;
      foreach (heap[i]) heap[i] = '0;
      put(0, hw - 2);
      put(1, NIL_WORD);
    endfunction

    function void configure(logic [HW_W-1:0] value);
      longint unsigned v;
      v = value;
      if (v < 8) v = 8;
      if (v > HEAP_WORDS) v = HEAP_WORDS;
      format_heap(v);
    endfunction

    function longint unsigned get(longint unsigned idx);
      if (idx >= words_in_use) return 0;
      return heap[idx];
    endfunction

    function void put(longint unsigned idx, longint unsigned v);
      if (idx < words_in_use) heap[idx] = v[WORD_BITS-1:0];
    endfunction

    function longint unsigned carve(longint unsigned n, longint unsigned s);
      longint unsigned sz, tail;
      sz = get(n);
      tail = n + sz - s;
      put(tail, s);
      put(tail + 1, USED_WORD);
      put(n, sz - (s + 2));
      return tail;
    endfunction

    function bit find_best(longint unsigned s, output longint unsigned tail);
      longint unsigned c, best, sz, steps;
      bit found;
      c = 0; best = 0; found = 0; steps = 0; tail = 0;
      while (c != NIL_WORD && c + 1 < words_in_use && steps < words_in_use) begin
        sz = get(c);
        if (sz >= s + 2 && (!found || sz < get(best))) begin
          best = c;
          found = 1;
        end
        c = get(c + 1);
        steps++;
      end
      if (!found) return 0;
      tail = carve(best, s);
      return 1;
    endfunction

    function void coalesce();
      longint unsigned p, c, csz, nextc, steps;
      p = 0; steps = 0;
      if (get(1) == NIL_WORD) return;
      c = get(0) + 2;
      while (c <= words_in_use - 1 && steps < words_in_use) begin
        csz = get(c);
        nextc = c + csz + 2;
        if (get(p + 1) != USED_WORD && get(c + 1) != USED_WORD) begin
          put(p, get(p) + csz + 2);
          put(p + 1, get(c + 1));
        end else begin
          p = c;
        end
        c = nextc;
        steps++;
      end
    endfunction

    function void link_free(longint unsigned off);
      longint unsigned n, c, tmp, steps;
      c = 0; steps = 0;
      if (off < 2) return;
      n = off - 2;
      while (get(c + 1) != NIL_WORD && get(c + 1) < n && steps < words_in_use) begin
        c = get(c + 1);
        steps++;
      end
      tmp = get(c + 1);
      put(c + 1, n);
      put(n + 1, tmp);
    endfunction

    function alloc_result_t note_request(req_op_e op, logic [SIZE_W-1:0] size,
                                         logic [OFF_W-1:0] off);
      alloc_result_t   r;
      longint unsigned tail;
      r = '0;
      last_handle = 0;
      if (op == REQ_FREE) begin
        link_free(off);
      end else if (!find_best(size, tail)) begin
        coalesce();
        if (!find_best(size, tail)) r.status = ST_NO_SPACE;
        else last_handle = tail + 2;
      end else begin
        last_handle = tail + 2;
      end
      r.data_offset = last_handle[OFF_W-1:0];
      awaited.push_back(r);
      return r;
    endfunction

    function void check_result(logic [OFF_W-1:0] off, logic status);
      alloc_result_t e;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: offset %0d status %0d",
                                       off, status);
        return;
      end
      e = awaited.pop_front();
      if (e.data_offset !== off || e.status !== status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result mismatch: expected offset %0d status %0d, got offset %0d status %0d",
                   e.data_offset, e.status, off, status);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [HW_W-1:0] cfg_wdata_i;

  bfha_in_if  req_if ();
  bfha_out_if res_if ();

  best_fit_heap_allocator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (res_if)
  );

  heap_scoreboard  sb;
  idle_mode_e      mode;
  bit              hold_req;
  longint unsigned handles [$];
  int unsigned     cycles;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_best_fit_heap_allocator_top NOT OK");
      $finish;
    end
  end

  function bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function void drop_handle(longint unsigned off);
    for (int i = handles.size() - 1; i >= 0; i--) if (handles[i] == off) handles.delete(i);
  endfunction

  task automatic send(req_op_e op, logic [SIZE_W-1:0] size, logic [OFF_W-1:0] off);
    alloc_result_t r;
    int unsigned   pct;
    pct = (mode == IDLE_SEND) ? 83 : (mode == IDLE_BOTH) ? 16 : 0;
    while (chance(pct)) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid        = 1'b1;
    req_if.operation    = op;
    req_if.request_size = size;
    req_if.block_offset = off;
    forever begin
      @(posedge clk_i);
      if (req_if.ready) break;
      @(negedge clk_i);
    end
    r = sb.note_request(op, size, off);
    if (op == REQ_ALLOC && r.status == ST_DONE && sb.last_handle < HEAP_WORDS)
      handles.push_back(sb.last_handle);
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_if.valid = 1'b0;
    while (sb.pending() > 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_heap_words(logic [HW_W-1:0] value);
    drain();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.configure(value);
    handles.delete();
  endtask

  task automatic random_items(int unsigned count, int unsigned size_max);
    int unsigned r, k;
    longint unsigned h;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send(REQ_FREE, SIZE_W'($urandom), OFF_W'($urandom_range(0, 1)));
      end else if (r < 48 && handles.size() > 0) begin
        k = $urandom_range(0, handles.size() - 1);
        h = handles[k];
        handles.delete(k);
        send(REQ_FREE, SIZE_W'($urandom), h[OFF_W-1:0]);
      end else if (r < 53) begin
        send(REQ_ALLOC, SIZE_W'($urandom_range(0, 4095)), OFF_W'($urandom));
      end else begin
        send(REQ_ALLOC, SIZE_W'($urandom_range(0, size_max)), OFF_W'($urandom));
      end
    end
  endtask

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      res_if.ready = !chance((mode == IDLE_RECV) ? 83 : (mode == IDLE_BOTH) ? 16 : 0);
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) sb.check_result(res_if.data_offset, res_if.status);
    end
  end

  initial begin
    sb = new();
    sb.configure(HW_W'(HEAP_WORDS));
    mode                = IDLE_NONE;
    hold_req            = 1'b0;
    cycles              = 0;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    req_if.valid        = 1'b0;
    req_if.operation    = REQ_ALLOC;
    req_if.request_size = '0;
    req_if.block_offset = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send(REQ_ALLOC, 12'd4094, '0);
    send(REQ_ALLOC, 12'd4092, '0);
    send(REQ_FREE, '0, 12'd4);
    drop_handle(4);
    send(REQ_ALLOC, 12'd0, '0);
    send(REQ_FREE, '0, 12'd0);
    send(REQ_FREE, '0, 12'd1);
    send(REQ_ALLOC, 12'd4095, '0);
    send(REQ_ALLOC, 12'd1, '0);
    random_items(100, 900);

    write_heap_words(HW_W'(0));
    send(REQ_ALLOC, 12'd0, '0);
    send(REQ_ALLOC, 12'd2, '0);
    send(REQ_ALLOC, 12'd0, '0);
    send(REQ_FREE, '0, 12'd4);
    send(REQ_FREE, '0, 12'd8);
    handles.delete();
    send(REQ_ALLOC, 12'd4, '0);
    send(REQ_FREE, '0, 12'd4000);
    mode = IDLE_SEND;
    random_items(150, 8);

    write_heap_words(HW_W'(128));
    mode = IDLE_RECV;
    random_items(550, 20);

    write_heap_words(HW_W'(200));
    mode = IDLE_BOTH;
    random_items(300, 24);
    drain();
    random_items(300, 24);

    write_heap_words(HW_W'(64));
    mode = IDLE_NONE;
    hold_req = 1'b1;
    random_items(150, 10);
    mode = IDLE_SEND;
    random_items(250, 10);

    write_heap_words(HW_W'(8191));
    mode = IDLE_BOTH;
    random_items(150, 1500);

    drain();
    repeat (200) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_best_fit_heap_allocator_top OK");
    end else begin
      $display("tb_best_fit_heap_allocator_top NOT OK");
    end
    $finish;
  end
endmodule
